/* hdl/bpi_pkg.sv */
// Types, codes and microprogram table for the tree pool insert/find block.
package bpi_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    typedef enum logic [2:0] {
        STEP_IDLE   = 3'd0,
        STEP_WALK   = 3'd1,
        STEP_DECIDE = 3'd2,
        STEP_LINK   = 3'd3,
        STEP_EMIT   = 3'd4
    } step_t;

    typedef enum logic [2:0] {
        COND_ALWAYS    = 3'd0,
        COND_IN_ACCEPT = 3'd1,
        COND_WALK_DONE = 3'd2,
        COND_ALLOC     = 3'd3,
        COND_OUT_FREE  = 3'd4
    } cond_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_POOL_FULL = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef struct packed {
        logic  start;
        logic  walk;
        logic  decide;
        logic  link;
        logic  emit;
        cond_t cond;
        step_t t_true;
        step_t t_false;
    } ctl_t;

    // Control store: one word per step.
    function automatic ctl_t ucode(input step_t step);
        ctl_t w;
        w = '{start: 1'b0, walk: 1'b0, decide: 1'b0, link: 1'b0, emit: 1'b0,
              cond: COND_ALWAYS, t_true: STEP_IDLE, t_false: STEP_IDLE};
        case (step)
            STEP_IDLE:
            begin
                w.start   = 1'b1;
                w.cond    = COND_IN_ACCEPT;
                w.t_true  = STEP_WALK;
                w.t_false = STEP_IDLE;
            end
            STEP_WALK:
            begin
                w.walk    = 1'b1;
                w.cond    = COND_WALK_DONE;
                w.t_true  = STEP_DECIDE;
                w.t_false = STEP_WALK;
            end
            STEP_DECIDE:
            begin
                w.decide  = 1'b1;
                w.cond    = COND_ALLOC;
                w.t_true  = STEP_LINK;
                w.t_false = STEP_EMIT;
            end
            STEP_LINK:
            begin
                w.link    = 1'b1;
                w.cond    = COND_ALWAYS;
                w.t_true  = STEP_EMIT;
                w.t_false = STEP_EMIT;
            end
            STEP_EMIT:
            begin
                w.emit    = 1'b1;
                w.cond    = COND_OUT_FREE;
                w.t_true  = STEP_IDLE;
                w.t_false = STEP_EMIT;
            end
            default:
            begin
                w.cond    = COND_ALWAYS;
                w.t_true  = STEP_IDLE;
                w.t_false = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* hdl/bst_pool_insert_find.sv */
// Binary search tree in a fixed node pool: insert or find one key per word.
// Steps: walk the tree from the root, decide the status, link a new node when one is
// allocated, then emit the result once the output is free. One node compared per cycle.
// Throughput: one word at a time; the next word is taken once the previous result is
// registered, while that result may still wait at the output.
// Reset clears the step counter, node count, height and visit total; pool entries are not
// cleared, and their contents are only used after they have been written.
module bst_pool_insert_find #(
    parameter int POOL_SIZE = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [31:0] key,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [5:0]  visits,
    output logic [5:0]  height,
    output logic [31:0] insert_visit_total
);
    import bpi_pkg::*;

    localparam int CW = $clog2(POOL_SIZE + 2);
    localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam logic [CW-1:0] NO_LINK = CW'(POOL_SIZE);

    logic [31:0]   node_key_mem   [POOL_SIZE];
    logic [CW-1:0] left_link_mem  [POOL_SIZE];
    logic [CW-1:0] right_link_mem [POOL_SIZE];

    step_t         step_reg, step_next;
    ctl_t          ctl;
    logic          cond_true;

    logic          op_reg, op_next;
    logic [31:0]   key_reg, key_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] parent_reg, parent_next;
    logic          go_left_reg, go_left_next;
    logic          hit_reg, hit_next;
    status_t       st_reg, st_next;
    logic [CW-1:0] node_count_reg, node_count_next;
    logic [CW-1:0] hpo_reg, hpo_next;
    logic [31:0]   total_reg, total_next;

    logic          out_valid_reg, out_valid_next;
    status_t       out_status_reg, out_status_next;
    logic [5:0]    out_visits_reg, out_visits_next;
    logic [5:0]    out_height_reg, out_height_next;
    logic [31:0]   out_total_reg, out_total_next;

    logic [31:0]   rd_key_reg;
    logic [CW-1:0] rd_left_reg, rd_right_reg;
    logic [AW-1:0] rd_addr;

    logic          node_ok, key_eq, key_lt, pool_full, alloc;
    logic [32:0]   total_sum;
    logic [CW-1:0] n_plus_one;

    logic          key_we;
    logic          left_we, right_we;
    logic [AW-1:0] lk_addr;
    logic [CW-1:0] lk_data;

    assign ctl        = ucode(step_reg);
    assign in_stall   = ~ctl.start;

    assign node_ok    = (cur_reg < node_count_reg) && (cur_reg < NO_LINK) && (n_reg < NO_LINK);
    assign key_eq     = (rd_key_reg == key_reg);
    assign key_lt     = $signed(key_reg) < $signed(rd_key_reg);
    assign pool_full  = (node_count_reg >= NO_LINK);
    assign alloc      = (op_reg == OP_INSERT) & ~hit_reg & ~pool_full;
    assign total_sum  = {1'b0, total_reg} + 33'(n_reg);
    assign n_plus_one = n_reg + CW'(1);

    // Condition select for the jump
    always_comb
    begin
        case (ctl.cond)
            COND_ALWAYS:    cond_true = 1'b1;
            COND_IN_ACCEPT: cond_true = in_valid;
            COND_WALK_DONE: cond_true = ~node_ok | key_eq;
            COND_ALLOC:     cond_true = alloc;
            COND_OUT_FREE:  cond_true = ~out_valid_reg | ~out_stall;
            default:        cond_true = 1'b1;
        endcase
    end

    // Next step
    always_comb
    begin
        step_next = cond_true ? ctl.t_true : ctl.t_false;
    end

    // Datapath driven by the control word
    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        cur_next        = cur_reg;
        n_next          = n_reg;
        parent_next     = parent_reg;
        go_left_next    = go_left_reg;
        hit_next        = hit_reg;
        st_next         = st_reg;
        node_count_next = node_count_reg;
        hpo_next        = hpo_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg & out_stall;
        out_status_next = out_status_reg;
        out_visits_next = out_visits_reg;
        out_height_next = out_height_reg;
        out_total_next  = out_total_reg;
        key_we          = 1'b0;
        left_we         = 1'b0;
        right_we        = 1'b0;
        lk_addr         = '0;
        lk_data         = NO_LINK;

        if (ctl.start && cond_true)
        begin
            op_next      = op;
            key_next     = key;
            cur_next     = (node_count_reg != '0) ? '0 : NO_LINK;
            n_next       = '0;
            parent_next  = NO_LINK;
            go_left_next = 1'b0;
            hit_next     = 1'b0;
        end

        if (ctl.walk && node_ok)
        begin
            n_next      = n_plus_one;
            parent_next = cur_reg;
            if (key_eq)
            begin
                hit_next = 1'b1;
            end
            else
            begin
                go_left_next = key_lt;
                cur_next     = key_lt ? rd_left_reg : rd_right_reg;
            end
        end

        if (ctl.decide)
        begin
            if (op_reg == OP_INSERT)
            begin
                total_next = total_sum[32] ? '1 : total_sum[31:0];
            end
            if (op_reg == OP_FIND)
                st_next = hit_reg ? ST_FOUND : ST_NOT_FOUND;
            else if (hit_reg)
                st_next = ST_PRESENT;
            else if (pool_full)
                st_next = ST_POOL_FULL;
            else
                st_next = ST_INSERTED;
            // Fresh node: key and both links empty
            if (alloc)
            begin
                key_we   = 1'b1;
                left_we  = 1'b1;
                right_we = 1'b1;
                lk_addr  = node_count_reg[AW-1:0];
                lk_data  = NO_LINK;
            end
        end

        if (ctl.link)
        begin
            if (parent_reg < NO_LINK)
            begin
                left_we  = go_left_reg;
                right_we = ~go_left_reg;
                lk_addr  = parent_reg[AW-1:0];
                lk_data  = node_count_reg;
            end
            node_count_next = node_count_reg + CW'(1);
            if (n_plus_one > hpo_reg)
                hpo_next = n_plus_one;
        end

        if (ctl.emit && cond_true)
        begin
            out_valid_next  = 1'b1;
            out_status_next = st_reg;
            out_visits_next = 6'(n_reg);
            out_height_next = 6'(hpo_reg) - 6'd1;
            out_total_next  = total_reg;
        end
    end

    assign rd_addr = (cur_next < NO_LINK) ? cur_next[AW-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (key_we)
            node_key_mem[lk_addr] <= key_reg;
        rd_key_reg <= node_key_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (left_we)
            left_link_mem[lk_addr] <= lk_data;
        rd_left_reg <= left_link_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (right_we)
            right_link_mem[lk_addr] <= lk_data;
        rd_right_reg <= right_link_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= STEP_IDLE;
            node_count_reg <= '0;
            hpo_reg        <= '0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            step_reg       <= step_next;
            node_count_reg <= node_count_next;
            hpo_reg        <= hpo_next;
            total_reg      <= total_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        cur_reg        <= cur_next;
        n_reg          <= n_next;
        parent_reg     <= parent_next;
        go_left_reg    <= go_left_next;
        hit_reg        <= hit_next;
        st_reg         <= st_next;
        out_status_reg <= out_status_next;
        out_visits_reg <= out_visits_next;
        out_height_reg <= out_height_next;
        out_total_reg  <= out_total_next;
    end

    assign out_valid          = out_valid_reg;
    assign status             = out_status_reg;
    assign visits             = out_visits_reg;
    assign height             = out_height_reg;
    assign insert_visit_total = out_total_reg;

    a_count_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        node_count_reg <= NO_LINK)
        else $error("node count beyond pool size");

    a_height_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        hpo_reg <= node_count_reg)
        else $error("tree height exceeds node count");

    a_alloc_only_in_link: assert property (@(posedge clk) disable iff (!rst_n)
        (node_count_reg != $past(node_count_reg)) |-> ($past(step_reg) == STEP_LINK))
        else $error("node count moved outside the link step");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(step_reg) == STEP_EMIT))
        else $error("result word raised outside the emit step");

    a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_WALK) |-> (n_reg <= NO_LINK))
        else $error("walk ran past pool size");

endmodule
